/* rtl/core/rhsm_pkg.sv */
package rhsm_pkg;

  // Storage and field sizes
  localparam int PATTERN_MAX = 32;
  localparam int DATA_W      = 8;
  localparam int IDX_W       = 5;
  localparam int OP_W        = 2;
  localparam int LEN_W       = 6;
  localparam int HASH_W      = 32;
  localparam int POS_W       = 32;
  localparam int PTR_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_W       = $clog2(PATTERN_MAX + 1);

  // Stream word layouts
  localparam int IN_TDATA_W   = ((DATA_W + IDX_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = OP_W;
  localparam int OUT_TDATA_W  = ((POS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 1;

  // Operation codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Pattern rehash sequencer
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HASH = 1'b1
  } hash_state_t;

  // Strobes shared by every cell of the chain
  typedef struct packed {
    logic text_shift;
    logic text_clear;
    logic pat_shift;
  } cell_ctl_t;

endpackage

/* rtl/core/rhsm_cell.sv */
module rhsm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  rhsm_pkg::cell_ctl_t          ctl,
  input  logic                         active,
  input  logic [rhsm_pkg::DATA_W-1:0]  win_in,
  input  logic [rhsm_pkg::DATA_W-1:0]  pat_in,
  output logic [rhsm_pkg::DATA_W-1:0]  win_q,
  output logic [rhsm_pkg::DATA_W-1:0]  pat_q,
  output logic                         eq
);

  // One text byte and the aligned pattern byte it is compared against.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_q <= '0;
      pat_q <= '0;
    end else begin
      if (ctl.text_clear) begin
        win_q <= '0;
      end else if (ctl.text_shift) begin
        win_q <= win_in;
      end
      if (ctl.pat_shift) begin
        pat_q <= pat_in;
      end
    end
  end

  // Cells beyond the pattern length never veto a match.
  assign eq = !active || (win_q == pat_q);

endmodule

/* rtl/core/rhsm_pattern.sv */
module rhsm_pattern (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_wr,
  input  logic [rhsm_pkg::IDX_W-1:0]   load_idx,
  input  logic [rhsm_pkg::DATA_W-1:0]  load_data,
  input  logic                         len_wr,
  input  logic [rhsm_pkg::LEN_W-1:0]   len_data,
  output logic [rhsm_pkg::CNT_W-1:0]   n,
  output logic [rhsm_pkg::DATA_W-1:0]  pat_byte,
  output logic                         pat_shift,
  output logic                         busy,
  output logic [rhsm_pkg::HASH_W-1:0]  pattern_hash
);

  logic [rhsm_pkg::DATA_W-1:0] store [rhsm_pkg::PATTERN_MAX];
  logic [rhsm_pkg::LEN_W-1:0]  pattern_length;
  logic [rhsm_pkg::PTR_W-1:0]  k, k_next;
  logic [rhsm_pkg::HASH_W-1:0] pattern_hash_next;
  rhsm_pkg::hash_state_t       state, state_next;
  logic [rhsm_pkg::PTR_W-1:0]  last_k;
  logic                        start;

  // Length in use, clamped to 1..PATTERN_MAX.
  always_comb begin
    if (pattern_length == '0) begin
      n = rhsm_pkg::CNT_W'(1);
    end else if (32'(pattern_length) > 32'(rhsm_pkg::PATTERN_MAX)) begin
      n = rhsm_pkg::CNT_W'(rhsm_pkg::PATTERN_MAX);
    end else begin
      n = rhsm_pkg::CNT_W'(pattern_length);
    end
  end

  assign last_k   = rhsm_pkg::PTR_W'(n - rhsm_pkg::CNT_W'(1));
  assign start    = load_wr || len_wr;
  assign pat_byte = store[k];
  assign busy     = (state == rhsm_pkg::ST_HASH);

  // Pattern store and length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rhsm_pkg::PATTERN_MAX; i++) begin
        store[i] <= '0;
      end
      pattern_length <= rhsm_pkg::LEN_W'(1);
    end else begin
      if (load_wr && (32'(load_idx) < 32'(rhsm_pkg::PATTERN_MAX))) begin
        store[rhsm_pkg::PTR_W'(load_idx)] <= load_data;
      end
      if (len_wr) begin
        pattern_length <= len_data;
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rhsm_pkg::ST_IDLE;
      k            <= '0;
      pattern_hash <= '0;
    end else begin
      state        <= state_next;
      k            <= k_next;
      pattern_hash <= pattern_hash_next;
    end
  end

  // Horner sweep over the first n bytes, one byte a cycle; each byte also
  // shifts into the cell chain so that cell j ends up holding byte n-1-j.
  always_comb begin
    state_next        = state;
    k_next            = k;
    pattern_hash_next = pattern_hash;
    pat_shift         = 1'b0;
    case (state)
      rhsm_pkg::ST_IDLE: begin
        if (start) begin
          state_next        = rhsm_pkg::ST_HASH;
          k_next            = '0;
          pattern_hash_next = '0;
        end
      end
      rhsm_pkg::ST_HASH: begin
        pat_shift         = 1'b1;
        pattern_hash_next = (pattern_hash << 1) + rhsm_pkg::HASH_W'(pat_byte);
        k_next            = k + rhsm_pkg::PTR_W'(1);
        if (k == last_k) begin
          state_next = rhsm_pkg::ST_IDLE;
          k_next     = '0;
        end
      end
      default: begin
        state_next = rhsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/rolling_hash_string_matcher_top.sv */
// Karp-Rabin string matcher over a byte stream.
// Input words arrive on s_axis: tuser holds the operation (load pattern
// byte, text byte, restart text), tdata holds the byte and the load index.
// The pattern length is written on the cfg channel while the block is idle.
// Each text byte, once the window holds the pattern length in bytes, gives
// one result word on m_axis: tuser bit 0 is the match flag, tdata is the
// text offset of the window's first byte.
// A text byte is taken every cycle unless a rehash, a waiting length write
// or a stalled output holds it off; its result goes through one compare
// stage and one output register. A pattern load or a length write starts a
// rehash that steps once per pattern byte through the first n bytes of the
// store, n being the length in use; s_axis and cfg are held off meanwhile.
// The window compare is done by a row of 32 cells, each holding one text
// byte and its aligned pattern byte.
// Reset clears the pattern, the window, both hashes and the offset, and
// sets the length to one; no rehash follows reset.
// When m_axis stalls, one result waits in the output register and one in
// the compare stage; further words are then held off on s_axis.
module rolling_hash_string_matcher_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] data, [12:8] index, [15:13] zero
  input  logic [rhsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [rhsm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] window_start
  output logic [rhsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] match
  output logic [rhsm_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rhsm_pkg::LEN_W-1:0]         cfg_data
);

  logic [rhsm_pkg::OP_W-1:0]   in_op;
  logic [rhsm_pkg::DATA_W-1:0] in_data;
  logic [rhsm_pkg::IDX_W-1:0]  in_index;
  logic                        in_acc, cfg_acc;
  logic                        is_load, is_text, is_restart;

  logic [rhsm_pkg::CNT_W-1:0]  n;
  logic [rhsm_pkg::DATA_W-1:0] pat_byte;
  logic                        pat_shift, busy;
  logic [rhsm_pkg::HASH_W-1:0] pattern_hash;

  logic [rhsm_pkg::DATA_W-1:0] win [rhsm_pkg::PATTERN_MAX];
  logic [rhsm_pkg::DATA_W-1:0] pat [rhsm_pkg::PATTERN_MAX];
  logic [rhsm_pkg::PATTERN_MAX-1:0] eq_vec;
  rhsm_pkg::cell_ctl_t         ctl;

  logic [rhsm_pkg::HASH_W-1:0] text_hash, text_hash_next;
  logic [rhsm_pkg::POS_W-1:0]  bytes_seen, bytes_seen_next;
  logic [rhsm_pkg::CNT_W-1:0]  fill, fill_next;
  logic [rhsm_pkg::DATA_W-1:0] leaving;
  logic [rhsm_pkg::HASH_W-1:0] leaving_term;

  logic                        pend;
  logic [rhsm_pkg::POS_W-1:0]  pend_ws;
  logic                        out_valid, out_match;
  logic [rhsm_pkg::POS_W-1:0]  out_ws;
  logic                        out_free, pend_move;

  // Word unpacking
  assign in_op    = s_axis_tuser[rhsm_pkg::OP_W-1:0];
  assign in_data  = s_axis_tdata[rhsm_pkg::DATA_W-1:0];
  assign in_index = s_axis_tdata[rhsm_pkg::DATA_W +: rhsm_pkg::IDX_W];

  // Handshakes: a waiting compare must be able to move on before any new word.
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !busy && (!pend || out_free) && !cfg_valid;
  assign cfg_ready     = !busy && !pend;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign pend_move     = pend && out_free;

  assign is_load    = in_acc && (in_op == rhsm_pkg::OP_LOAD);
  assign is_text    = in_acc && (in_op == rhsm_pkg::OP_TEXT);
  assign is_restart = in_acc && (in_op == rhsm_pkg::OP_RESTART);

  // Pattern store, length and rehash sequencer
  rhsm_pattern u_pattern (
    .clk          (clk),
    .rst          (rst),
    .load_wr      (is_load),
    .load_idx     (in_index),
    .load_data    (in_data),
    .len_wr       (cfg_acc),
    .len_data     (cfg_data),
    .n            (n),
    .pat_byte     (pat_byte),
    .pat_shift    (pat_shift),
    .busy         (busy),
    .pattern_hash (pattern_hash)
  );

  assign ctl.text_shift = is_text;
  assign ctl.text_clear = is_restart;
  assign ctl.pat_shift  = pat_shift;

  // Row of compare cells; cell 0 holds the newest text byte.
  for (genvar j = 0; j < rhsm_pkg::PATTERN_MAX; j++) begin : g_cell
    logic active;
    assign active = (32'(j) < 32'(n));
    if (j == 0) begin : g_head
      rhsm_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .active (active),
        .win_in (in_data),
        .pat_in (pat_byte),
        .win_q  (win[j]),
        .pat_q  (pat[j]),
        .eq     (eq_vec[j])
      );
    end else begin : g_body
      rhsm_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .active (active),
        .win_in (win[j-1]),
        .pat_in (pat[j-1]),
        .win_q  (win[j]),
        .pat_q  (pat[j]),
        .eq     (eq_vec[j])
      );
    end
  end

  // Rolling hash: the byte leaving the window is shifted by n, which drops
  // out entirely once n reaches the hash width.
  assign leaving = win[rhsm_pkg::PTR_W'(n - rhsm_pkg::CNT_W'(1))];
  always_comb begin
    if (32'(n) >= 32'(rhsm_pkg::HASH_W)) begin
      leaving_term = '0;
    end else begin
      leaving_term = rhsm_pkg::HASH_W'(leaving) << n;
    end
  end
  assign text_hash_next  = (text_hash << 1) - leaving_term + rhsm_pkg::HASH_W'(in_data);
  assign bytes_seen_next = bytes_seen + rhsm_pkg::POS_W'(1);
  assign fill_next       = (32'(fill) < 32'(rhsm_pkg::PATTERN_MAX)) ?
                           fill + rhsm_pkg::CNT_W'(1) : fill;

  // Text-side state.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_hash  <= '0;
      bytes_seen <= '0;
      fill       <= '0;
    end else if (is_restart) begin
      text_hash  <= '0;
      bytes_seen <= '0;
      fill       <= '0;
    end else if (is_text) begin
      text_hash  <= text_hash_next;
      bytes_seen <= bytes_seen_next;
      fill       <= fill_next;
    end
  end

  // Compare stage: flags a full window; its cells are compared as it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (is_text && (fill_next >= n)) begin
      pend <= 1'b1;
    end else if (pend_move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_text) begin
      pend_ws <= bytes_seen_next - rhsm_pkg::POS_W'(n);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_match <= (&eq_vec) && (text_hash == pattern_hash);
      out_ws    <= pend_ws;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = rhsm_pkg::OUT_TDATA_W'(out_ws);
  assign m_axis_tuser  = rhsm_pkg::OUT_TUSER_W'(out_match);

endmodule

/* rtl/core/rhsm_checker.sv */
module rhsm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [rhsm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rhsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [rhsm_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A length write starts a rehash, during which no word is taken.
  a_cfg_rehash: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_axis_tready && !cfg_ready)
    else $error("input taken during rehash after length write");

  // A pattern load also starts a rehash.
  a_load_rehash: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser[rhsm_pkg::OP_W-1:0] == rhsm_pkg::OP_LOAD) |=>
      !s_axis_tready && !cfg_ready)
    else $error("input taken during rehash after pattern load");

endmodule

bind rolling_hash_string_matcher_top rhsm_checker u_rhsm_checker (.*);

/* bench/tb_rolling_hash_string_matcher_top.sv */
`timescale 1ns / 100ps

module tb_rolling_hash_string_matcher_top;
  import rhsm_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [OP_W-1:0] OP_NOOP = 2'd3;

  localparam int ITEMS_TARGET = 900;
  localparam int SETTLE       = 40;
  localparam int LIMIT        = 600000;

  typedef struct {
    logic        match;
    logic [31:0] start;
  } hit_t;

  // Tracks the matcher state and compares each result word against it.
  class match_scoreboard;
    logic [7:0]  pattern [PATTERN_MAX];
    logic [7:0]  window [PATTERN_MAX];
    logic [31:0] pattern_hash;
    logic [31:0] text_hash;
    logic [31:0] bytes_seen;
    int unsigned window_fill;
    logic [5:0]  length_reg;
    hit_t        expected_hits[$];
    int          errors;

    function new();
      foreach (pattern[k]) pattern[k] = 8'd0;
      length_reg   = 6'd1;
      pattern_hash = 32'd0;
      errors       = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = 8'd0;
      text_hash   = 32'd0;
      bytes_seen  = 32'd0;
      window_fill = 0;
    endfunction

    // Zero acts as one, anything above the store size acts as the store size.
    function int unsigned length_used();
      int unsigned n;
      n = 32'(length_reg);
      if (n < 1) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      return n;
    endfunction

    // Terms shifted out of the word contribute nothing.
    function logic [31:0] shifted(logic [31:0] v, int unsigned s);
      return (s >= 32) ? 32'd0 : (v << s);
    endfunction

    function void rehash();
      int unsigned n;
      logic [31:0] h;
      n = length_used();
      h = 32'd0;
      for (int unsigned k = 0; k < n; k++) h += shifted({24'd0, pattern[k]}, n - 1 - k);
      pattern_hash = h;
    endfunction

    function void set_length(logic [5:0] v);
      length_reg = v;
      rehash();
    endfunction

    // Applies one accepted input word and queues the result it gives, if any.
    function void note_input(logic [1:0] op, logic [7:0] data, logic [4:0] index);
      int unsigned n;
      logic [7:0]  leaving;
      logic        eq;
      hit_t        h;
      if (op == OP_LOAD) begin
        pattern[index] = data;
        rehash();
      end else if (op == OP_RESTART) begin
        clear_text();
      end else if (op == OP_TEXT) begin
        n = length_used();
        leaving = window[n-1];
        text_hash = shifted(text_hash, 1) - shifted({24'd0, leaving}, n) + {24'd0, data};
        for (int k = PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = data;
        bytes_seen += 32'd1;
        if (window_fill < PATTERN_MAX) window_fill++;
        if (window_fill >= n) begin
          eq = (text_hash == pattern_hash);
          for (int unsigned k = 0; k < n; k++)
            if (window[n-1-k] != pattern[k]) eq = 1'b0;
          h.match = eq;
          h.start = bytes_seen - n;
          expected_hits.push_back(h);
        end
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic match, logic [31:0] start);
      hit_t h;
      if (expected_hits.size() == 0) begin
        report($sformatf("unexpected result word, start %0d match %0b", start, match));
        return;
      end
      h = expected_hits.pop_front();
      if (match !== h.match)
        report($sformatf("match flag %0b, wanted %0b (start %0d)", match, h.match, h.start));
      if (start !== h.start)
        report($sformatf("window start %0d, wanted %0d", start, h.start));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data;

  match_scoreboard sb = new();
  logic            calm;
  int              items_sent;
  int              stall_left;
  int              cycles;

  rolling_hash_string_matcher_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every handshake seen at the rising edge goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_length(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[12:8]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser[0], m_axis_tdata[31:0]);
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (calm) begin
      m_axis_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Bytes drawn mostly from a tiny alphabet so that chance matches happen.
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 4) != 0) return 8'(8'h41 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned clamp_length(int unsigned v);
    if (v < 1) return 1;
    if (v > PATTERN_MAX) return PATTERN_MAX;
    return v;
  endfunction

  // Offers one input word and returns just after the edge that takes it.
  task automatic send_word(logic [1:0] op, logic [7:0] data, logic [4:0] index);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b000, index, data};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op != OP_NOOP) items_sent++;
  endtask

  task automatic send_text(logic [7:0] data);
    send_word(OP_TEXT, data, 5'($urandom_range(0, 31)));
  endtask

  // Stops sending and waits until every result has come, then lets a
  // possible rehash finish.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [5:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random phase: a length, usually a fresh pattern, then a text that
  // mostly contains copies of the pattern among random bytes.
  task automatic run_phase();
    int unsigned pick;
    int unsigned n;
    int unsigned burst;
    int unsigned done;
    logic [5:0]  len;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = 6'($urandom_range(1, 8));
    else if (pick < 8) len = 6'($urandom_range(9, 32));
    else len = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
    write_length(len);
    calm = ($urandom_range(0, 4) == 0);
    n = clamp_length(32'(len));
    if ($urandom_range(0, 3) != 0)
      for (int unsigned k = 0; k < n; k++) send_word(OP_LOAD, rand_byte(), 5'(k));
    if (n < PATTERN_MAX && $urandom_range(0, 2) == 0)
      send_word(OP_LOAD, 8'($urandom_range(0, 255)),
                5'($urandom_range(n, PATTERN_MAX - 1)));
    if ($urandom_range(0, 1) != 0)
      send_word(OP_RESTART, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    burst = n + $urandom_range(20, 50);
    done = 0;
    while (done < burst) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        for (int unsigned k = 0; k < n; k++) send_text(sb.pattern[k]);
        done += n;
      end else begin
        if (pick < 90)
          send_text(rand_byte());
        else if (pick < 94)
          send_word(OP_NOOP, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        else if (pick < 97)
          send_word(OP_LOAD, rand_byte(), 5'($urandom_range(0, 31)));
        else
          send_word(OP_RESTART, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        done++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    calm          = 1'b0;
    items_sent    = 0;
    stall_left    = 0;
    cycles        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Length one straight out of reset: the cleared pattern matches a zero byte.
    send_text(8'h00);
    send_text(8'hFF);
    send_word(OP_LOAD, 8'hFF, 5'd0);
    send_text(8'hFF);
    send_word(OP_NOOP, 8'hA5, 5'd31);
    send_word(OP_RESTART, 8'h00, 5'd0);
    send_text(8'h00);

    // Length two: a window with the pattern's hash but different bytes.
    write_length(6'd2);
    send_word(OP_LOAD, 8'd1, 5'd0);
    send_word(OP_LOAD, 8'd0, 5'd1);
    send_word(OP_RESTART, 8'hFF, 5'd31);
    send_text(8'd0);
    send_text(8'd2);
    send_text(8'd1);
    send_text(8'd0);

    // Length three, plus a load beyond the length in use at the top index.
    write_length(6'd3);
    send_word(OP_LOAD, 8'h61, 5'd0);
    send_word(OP_LOAD, 8'h62, 5'd1);
    send_word(OP_LOAD, 8'h63, 5'd2);
    send_word(OP_LOAD, 8'hFF, 5'd31);
    send_text(8'h78);
    send_text(8'h61);
    send_text(8'h62);
    send_text(8'h63);

    // The full store, then lengths outside the range, with the window kept.
    write_length(6'd32);
    send_text(8'h55);
    write_length(6'd0);
    send_text(8'h55);
    write_length(6'd33);
    send_text(8'hAA);
    write_length(6'd63);
    send_text(8'h00);

    items_sent = 0;
    while (items_sent < ITEMS_TARGET) run_phase();

    // Drain and settle, then give the verdict.
    calm = 1'b0;
    wait_idle();
    if (sb.expected_hits.size() != 0)
      sb.report($sformatf("%0d expected results never came", sb.expected_hits.size()));
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
